// File: design/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int DATA_W      = 16;
   localparam int ONE_Q       = 1 << FRAC_BITS;
   localparam int SUM_W       = DATA_W + 3;
   localparam int VAL_W       = DATA_W + 1;
   localparam int NUM_W       = DATA_W + 1;
   localparam int ROOT_W      = 16;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int REM_W       = ROOT_W + 4;
   localparam int SQRT_STAGES = ROOT_W / 2;
   localparam int DIV_W       = ROOT_W + 1;
   localparam int QUO_W       = FRAC_BITS;
   localparam int DIV_STAGES  = QUO_W / 2;
   localparam int LANES       = 3;
   localparam int HALF_W      = ROOT_W - 1;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quat_w;
      logic signed [DATA_W-1:0] quat_x;
      logic signed [DATA_W-1:0] quat_y;
      logic signed [DATA_W-1:0] quat_z;
   } rsp_type;

   // nz: discriminant positive; diag: output slot that gets r/2
   typedef struct packed {
      logic                             nz;
      logic [1:0]                       diag;
      logic [LANES-1:0][NUM_W-1:0]      num;
   } job_type;

   typedef struct packed {
      job_type                          job;
      logic [RAD_W-1:0]                 rad;
      logic [REM_W-1:0]                 rem;
      logic [ROOT_W-1:0]                root;
   } sqrt_type;

   typedef struct packed {
      logic                             nz;
      logic [1:0]                       diag;
      logic [HALF_W-1:0]                half;
      logic [DIV_W-1:0]                 s;
      logic [LANES-1:0]                 neg;
      logic [LANES-1:0]                 ovf;
      logic [LANES-1:0][DIV_W-1:0]      rem;
      logic [LANES-1:0][QUO_W-1:0]      quo;
   } div_type;

endpackage
`default_nettype wire

// File: design/rmq_front.sv
`default_nettype none
module rmq_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire rmq_pkg::req_type in_data,
   output logic                  out_valid,
   output rmq_pkg::job_type      out_job,
   output logic [rmq_pkg::VAL_W-1:0] out_val
);

   logic                              valid_ff;
   rmq_pkg::job_type                  job_ff, job_in;
   logic [rmq_pkg::VAL_W-1:0]         val_ff, val_in;
   logic signed [rmq_pkg::SUM_W-1:0]  t, d0, d1, d2, dsel;
   logic signed [rmq_pkg::SUM_W-1:0]  a00, a11, a22, one_s;
   logic signed [rmq_pkg::NUM_W-1:0]  dx, dy, dz, sxy, sxz, syz;
   logic [1:0]                        sel;

   always_comb begin
      one_s = rmq_pkg::SUM_W'(rmq_pkg::ONE_Q);
      a00   = rmq_pkg::SUM_W'(in_data.m00);
      a11   = rmq_pkg::SUM_W'(in_data.m11);
      a22   = rmq_pkg::SUM_W'(in_data.m22);
      t     = one_s + a00 + a11 + a22;
      d0    = one_s + a00 - a11 - a22;
      d1    = one_s + a11 - a00 - a22;
      d2    = one_s + a22 - a00 - a11;
      dx    = rmq_pkg::NUM_W'(in_data.m21) - rmq_pkg::NUM_W'(in_data.m12);
      dy    = rmq_pkg::NUM_W'(in_data.m02) - rmq_pkg::NUM_W'(in_data.m20);
      dz    = rmq_pkg::NUM_W'(in_data.m10) - rmq_pkg::NUM_W'(in_data.m01);
      sxy   = rmq_pkg::NUM_W'(in_data.m01) + rmq_pkg::NUM_W'(in_data.m10);
      sxz   = rmq_pkg::NUM_W'(in_data.m02) + rmq_pkg::NUM_W'(in_data.m20);
      syz   = rmq_pkg::NUM_W'(in_data.m12) + rmq_pkg::NUM_W'(in_data.m21);
      // ties go to the later diagonal index
      if (in_data.m00 > in_data.m11) begin
         sel = (in_data.m00 > in_data.m22) ? 2'd0 : 2'd2;
      end else begin
         sel = (in_data.m11 > in_data.m22) ? 2'd1 : 2'd2;
      end
      case (sel)
         2'd0:    dsel = d0;
         2'd1:    dsel = d1;
         default: dsel = d2;
      endcase
      // lanes fill the three non-diagonal slots in ascending order
      if (t > 0) begin
         job_in.diag = 2'd0;
         job_in.num  = {dz, dy, dx};
         job_in.nz   = 1'b1;
         val_in      = t[rmq_pkg::VAL_W-1:0];
      end else begin
         case (sel)
            2'd0: begin
               job_in.diag = 2'd1;
               job_in.num  = {sxz, sxy, dx};
            end
            2'd1: begin
               job_in.diag = 2'd2;
               job_in.num  = {syz, sxy, dy};
            end
            default: begin
               job_in.diag = 2'd3;
               job_in.num  = {syz, sxz, dz};
            end
         endcase
         job_in.nz = (dsel > 0);
         val_in    = dsel[rmq_pkg::VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         job_ff <= job_in;
         val_ff <= val_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_job   = job_ff;
   assign out_val   = val_ff;

endmodule
`default_nettype wire

// File: design/rmq_sqrt.sv
`default_nettype none
module rmq_sqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire rmq_pkg::job_type          in_job,
   input  wire logic [rmq_pkg::VAL_W-1:0] in_val,
   output logic                           out_valid,
   output rmq_pkg::sqrt_type              out_data
);

   localparam int N = rmq_pkg::SQRT_STAGES;

   rmq_pkg::sqrt_type st_ff [N];
   rmq_pkg::sqrt_type st_in [N];
   logic [N-1:0]      valid_ff;

   // two result bits per stage, restoring digit-by-digit square root
   always_comb begin
      rmq_pkg::sqrt_type                 cur;
      logic [rmq_pkg::REM_W-1:0]         trial;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            cur.job  = in_job;
            cur.rad  = rmq_pkg::RAD_W'({in_val, rmq_pkg::FRAC_BITS'(0)});
            cur.rem  = '0;
            cur.root = '0;
         end else begin
            cur = st_ff[i-1];
         end
         for (int k = 0; k < 2; k++) begin
            cur.rem = {cur.rem[rmq_pkg::REM_W-3:0], cur.rad[rmq_pkg::RAD_W-1 -: 2]};
            cur.rad = {cur.rad[rmq_pkg::RAD_W-3:0], 2'b00};
            trial   = rmq_pkg::REM_W'({cur.root, 2'b01});
            if (cur.rem >= trial) begin
               cur.rem  = cur.rem - trial;
               cur.root = {cur.root[rmq_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               cur.root = {cur.root[rmq_pkg::ROOT_W-2:0], 1'b0};
            end
         end
         st_in[i] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < N; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_data  = st_ff[N-1];

endmodule
`default_nettype wire

// File: design/rmq_div.sv
`default_nettype none
module rmq_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire rmq_pkg::sqrt_type in_data,
   output logic                   out_valid,
   output rmq_pkg::div_type       out_data
);

   localparam int N = rmq_pkg::DIV_STAGES;
   localparam int W = rmq_pkg::DIV_W;

   rmq_pkg::div_type st_ff [N];
   rmq_pkg::div_type st_in [N];
   logic [N-1:0]     valid_ff;

   // |num|/s with two quotient bits per stage; |num| >= s saturates
   always_comb begin
      rmq_pkg::div_type           cur;
      logic [rmq_pkg::NUM_W-1:0]  mag;
      logic [W:0]                 r2;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            cur.nz   = in_data.job.nz;
            cur.diag = in_data.job.diag;
            cur.half = in_data.root[rmq_pkg::ROOT_W-1:1];
            cur.s    = {in_data.root, 1'b0};
            for (int l = 0; l < rmq_pkg::LANES; l++) begin
               cur.neg[l] = in_data.job.num[l][rmq_pkg::NUM_W-1];
               mag        = cur.neg[l] ? (~in_data.job.num[l] + 1'b1) : in_data.job.num[l];
               cur.ovf[l] = (W'(mag) >= cur.s);
               cur.rem[l] = W'(mag);
               cur.quo[l] = '0;
            end
         end else begin
            cur = st_ff[i-1];
         end
         for (int l = 0; l < rmq_pkg::LANES; l++) begin
            for (int k = 0; k < 2; k++) begin
               r2 = {cur.rem[l], 1'b0};
               if (r2 >= {1'b0, cur.s}) begin
                  r2         = r2 - {1'b0, cur.s};
                  cur.quo[l] = {cur.quo[l][rmq_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  cur.quo[l] = {cur.quo[l][rmq_pkg::QUO_W-2:0], 1'b0};
               end
               cur.rem[l] = r2[W-1:0];
            end
         end
         st_in[i] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < N; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_data  = st_ff[N-1];

endmodule
`default_nettype wire

// File: design/rotation_matrix_to_quaternion.sv
// Converts one row-major 3x3 rotation matrix (signed Q1.14) into a unit quaternion
// (w, x, y, z) by Shepperd's method, each component saturated to +/-1.0. One matrix
// is accepted every cycle while the output is not stalled; it passes the trace and
// branch selection register, the square-root stages (two root bits per stage), the
// three parallel dividers' stages (two quotient bits per stage) and the output
// register. The whole pipeline holds while a result waits on rsp_ready. A matrix
// whose discriminant is not positive (not a rotation) gives all zeros.
`default_nettype none
module rotation_matrix_to_quaternion (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rmq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rmq_pkg::rsp_type      rsp_data
);

   logic                          adv;
   logic                          f_valid, s_valid, d_valid;
   rmq_pkg::job_type              f_job;
   logic [rmq_pkg::VAL_W-1:0]     f_val;
   rmq_pkg::sqrt_type             s_data;
   rmq_pkg::div_type              d_data;
   logic                          rsp_valid_ff;
   rmq_pkg::rsp_type              rsp_ff, rsp_in;
   logic [3:0][rmq_pkg::DATA_W-1:0] slot;
   logic [rmq_pkg::LANES-1:0][rmq_pkg::DATA_W-1:0] lane_q;
   logic [rmq_pkg::DATA_W-1:0]    half_q, mag;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   rmq_front u_front (
      .clock, .reset, .adv,
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_job   (f_job),
      .out_val   (f_val)
   );

   rmq_sqrt u_sqrt (
      .clock, .reset, .adv,
      .in_valid  (f_valid),
      .in_job    (f_job),
      .in_val    (f_val),
      .out_valid (s_valid),
      .out_data  (s_data)
   );

   rmq_div u_div (
      .clock, .reset, .adv,
      .in_valid  (s_valid),
      .in_data   (s_data),
      .out_valid (d_valid),
      .out_data  (d_data)
   );

   always_comb begin
      half_q = (rmq_pkg::DATA_W'(d_data.half) > rmq_pkg::DATA_W'(rmq_pkg::ONE_Q)) ?
               rmq_pkg::DATA_W'(rmq_pkg::ONE_Q) : rmq_pkg::DATA_W'(d_data.half);
      for (int l = 0; l < rmq_pkg::LANES; l++) begin
         mag       = d_data.ovf[l] ? rmq_pkg::DATA_W'(rmq_pkg::ONE_Q)
                                   : rmq_pkg::DATA_W'(d_data.quo[l]);
         lane_q[l] = d_data.neg[l] ? (~mag + 1'b1) : mag;
      end
      for (int j = 0; j < 4; j++) begin
         if (!d_data.nz) begin
            slot[j] = '0;
         end else if (d_data.diag == 2'(j)) begin
            slot[j] = half_q;
         end else if (2'(j) > d_data.diag) begin
            slot[j] = lane_q[(j == 0) ? 0 : j-1];
         end else begin
            slot[j] = lane_q[(j == 3) ? 2 : j];
         end
      end
      rsp_in.quat_w = slot[0];
      rsp_in.quat_x = slot[1];
      rsp_in.quat_y = slot[2];
      rsp_in.quat_z = slot[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: design/rmq_checker.sv
`default_nettype none
module rmq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire rmq_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rmq_pkg::rsp_type rsp_data
);

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with output free");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.quat_w <= 16384 && rsp_data.quat_w >= -16384 &&
                    rsp_data.quat_x <= 16384 && rsp_data.quat_x >= -16384 &&
                    rsp_data.quat_y <= 16384 && rsp_data.quat_y >= -16384 &&
                    rsp_data.quat_z <= 16384 && rsp_data.quat_z >= -16384)
      else $error("quaternion component out of range");

   a_reset: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
`default_nettype wire
